@@ src/kmtt_pkg.sv @@
// Shared types and constants of the keyed multi-timer table
`timescale 1ns / 1ps

package kmtt_pkg;

    localparam int OP_W   = 2;
    localparam int ID_W   = 16;
    localparam int DUR_W  = 31;
    localparam int TIME_W = 32;
    localparam int KIND_W = 3;
    localparam int SLOT_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_SET   = 2'd0,
        OP_UNSET = 2'd1,
        OP_TICK  = 2'd2
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_SET_OK     = 3'd0,
        KIND_SET_FULL   = 3'd1,
        KIND_UNSET_DONE = 3'd2,
        KIND_UNSET_MISS = 3'd3,
        KIND_EXPIRY     = 3'd4
    } kind_t;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic eval_hit;
        logic eval_last;
        logic hold_valid;
        logic out_free;
    } status_t;

endpackage

@@ src/kmtt_in_if.sv @@
// Input channel: timer commands and ticks
`timescale 1ns / 1ps

interface kmtt_in_if;
    logic                         valid;
    logic                         ready;
    logic [kmtt_pkg::OP_W-1:0]    opcode;
    logic [kmtt_pkg::ID_W-1:0]    owner_id;
    logic [kmtt_pkg::ID_W-1:0]    event_id;
    logic [kmtt_pkg::DUR_W-1:0]   duration_ms;
    logic                         is_periodic;
    logic [kmtt_pkg::TIME_W-1:0]  now_ms;

    modport source (
        output valid, opcode, owner_id, event_id, duration_ms, is_periodic, now_ms,
        input  ready
    );
    modport sink (
        input  valid, opcode, owner_id, event_id, duration_ms, is_periodic, now_ms,
        output ready
    );
endinterface

@@ src/kmtt_out_if.sv @@
// Output channel: command results and expiry events
`timescale 1ns / 1ps

interface kmtt_out_if;
    logic                         valid;
    logic                         ready;
    logic [kmtt_pkg::KIND_W-1:0]  kind;
    logic [kmtt_pkg::ID_W-1:0]    out_owner;
    logic [kmtt_pkg::ID_W-1:0]    out_event;
    logic [kmtt_pkg::SLOT_W-1:0]  slot_index;
    logic                         last;

    modport source (
        output valid, kind, out_owner, out_event, slot_index, last,
        input  ready
    );
    modport sink (
        input  valid, kind, out_owner, out_event, slot_index, last,
        output ready
    );
endinterface

@@ src/kmtt_ctrl.sv @@
// Controller state machine sequencing the slot scan of each set, unset or tick
`timescale 1ns / 1ps

module kmtt_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [kmtt_pkg::OP_W-1:0]  in_op,
    output logic                       in_ready,
    output kmtt_pkg::cmd_t             cmd,
    input  kmtt_pkg::status_t          st
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   stall;
    logic   op_known;

    always_comb
    begin
        stall      = st.eval_hit && st.hold_valid && !st.out_free;
        op_known   = (in_op == kmtt_pkg::OP_SET) || (in_op == kmtt_pkg::OP_UNSET) ||
                     (in_op == kmtt_pkg::OP_TICK);
        in_ready   = (state_reg == ST_IDLE);
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (op_known)
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (!stall)
                begin
                    cmd.step = 1'b1;
                    if (st.eval_last)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ src/kmtt_dp.sv @@
// Datapath: slot memories, active flags, scan pipeline and result register
`timescale 1ns / 1ps

module kmtt_dp #(
    parameter int NUM_SLOTS = 20
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  kmtt_pkg::cmd_t                cmd,
    output kmtt_pkg::status_t             st,
    input  logic [kmtt_pkg::OP_W-1:0]     in_opcode,
    input  logic [kmtt_pkg::ID_W-1:0]     in_owner,
    input  logic [kmtt_pkg::ID_W-1:0]     in_event,
    input  logic [kmtt_pkg::DUR_W-1:0]    in_duration,
    input  logic                          in_periodic,
    input  logic [kmtt_pkg::TIME_W-1:0]   in_now,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [kmtt_pkg::KIND_W-1:0]   out_kind,
    output logic [kmtt_pkg::ID_W-1:0]     out_owner,
    output logic [kmtt_pkg::ID_W-1:0]     out_event,
    output logic [kmtt_pkg::SLOT_W-1:0]   out_slot,
    output logic                          out_last
);

    localparam int IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam int ID_W   = kmtt_pkg::ID_W;
    localparam int DUR_W  = kmtt_pkg::DUR_W;
    localparam int TIME_W = kmtt_pkg::TIME_W;
    localparam int CFG_W  = 2 * ID_W + DUR_W + 1;
    localparam int OSW    = kmtt_pkg::SLOT_W;

    // item
    logic [kmtt_pkg::OP_W-1:0] op_reg;
    logic [ID_W-1:0]           owner_reg;
    logic [ID_W-1:0]           event_reg;
    logic [DUR_W-1:0]          dur_reg;
    logic                      per_reg;
    logic [TIME_W-1:0]         now_reg;

    // slot storage
    logic [CFG_W-1:0]     cfg_mem   [NUM_SLOTS];
    logic [TIME_W-1:0]    start_mem [NUM_SLOTS];
    logic [CFG_W-1:0]     cfg_rd_reg;
    logic [TIME_W-1:0]    start_rd_reg;
    logic [NUM_SLOTS-1:0] active_reg;

    // scan
    logic [CNT_W-1:0] rd_cnt_reg;
    logic             eval_valid_reg;
    logic [IDX_W-1:0] eval_idx_reg;
    logic             match_found_reg;
    logic [IDX_W-1:0] match_idx_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;

    // pending expiry
    logic             hold_valid_reg;
    logic [ID_W-1:0]  hold_owner_reg;
    logic [ID_W-1:0]  hold_event_reg;
    logic [IDX_W-1:0] hold_idx_reg;

    // result register
    logic                        out_valid_reg;
    logic [kmtt_pkg::KIND_W-1:0] out_kind_reg;
    logic [ID_W-1:0]             out_owner_reg;
    logic [ID_W-1:0]             out_event_reg;
    logic [OSW-1:0]              out_slot_reg;
    logic                        out_last_reg;

    logic                        out_kind_next;
    logic [kmtt_pkg::KIND_W-1:0] kind_next;
    logic [ID_W-1:0]             owner_next;
    logic [ID_W-1:0]             event_next;
    logic [OSW-1:0]              slot_next;
    logic                        last_next;

    logic              rd_more;
    logic [IDX_W-1:0]  rd_addr;
    logic              rd_en;
    logic [ID_W-1:0]   slot_owner;
    logic [ID_W-1:0]   slot_event;
    logic [DUR_W-1:0]  slot_dur;
    logic              slot_per;
    logic              eval_active;
    logic              key_hit;
    logic [TIME_W-1:0] elapsed;
    logic              expired;
    logic              is_set;
    logic              is_unset;
    logic              is_tick;
    logic              eval_hit;
    logic              set_hit;
    logic [IDX_W-1:0]  set_idx;
    logic              cfg_we;
    logic              start_we;
    logic [IDX_W-1:0]  wr_idx;
    logic              push_mid;
    logic              push_fin;
    logic              push;

    always_comb
    begin
        rd_more     = rd_cnt_reg < CNT_W'(NUM_SLOTS);
        rd_addr     = rd_cnt_reg[IDX_W-1:0];
        rd_en       = cmd.step && rd_more;
        {slot_owner, slot_event, slot_dur, slot_per} = cfg_rd_reg;
        eval_active = eval_valid_reg && active_reg[eval_idx_reg];
        key_hit     = eval_active && (slot_owner == owner_reg) && (slot_event == event_reg);
        elapsed     = now_reg - start_rd_reg;
        expired     = elapsed >= {1'b0, slot_dur};
        is_set      = (op_reg == kmtt_pkg::OP_SET);
        is_unset    = (op_reg == kmtt_pkg::OP_UNSET);
        is_tick     = (op_reg == kmtt_pkg::OP_TICK);
        eval_hit    = is_tick && eval_active && expired;
        set_hit     = match_found_reg || free_found_reg;
        set_idx     = match_found_reg ? match_idx_reg : free_idx_reg;
        cfg_we      = cmd.finish && is_set && set_hit;
        start_we    = cfg_we || (cmd.step && eval_hit && slot_per);
        wr_idx      = cmd.finish ? set_idx : eval_idx_reg;
        push_mid    = cmd.step && eval_hit && hold_valid_reg;
        push_fin    = cmd.finish && (!is_tick || hold_valid_reg);
        push        = push_mid || push_fin;

        st.eval_hit   = eval_hit;
        st.eval_last  = eval_valid_reg && (eval_idx_reg == IDX_W'(NUM_SLOTS - 1));
        st.hold_valid = hold_valid_reg;
        st.out_free   = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        out_kind_next = 1'b0;
        kind_next     = kmtt_pkg::KIND_EXPIRY;
        owner_next    = hold_owner_reg;
        event_next    = hold_event_reg;
        slot_next     = OSW'(hold_idx_reg);
        last_next     = push_fin;
        if (push_fin && is_set)
        begin
            kind_next  = set_hit ? kmtt_pkg::KIND_SET_OK : kmtt_pkg::KIND_SET_FULL;
            owner_next = owner_reg;
            event_next = event_reg;
            slot_next  = set_hit ? OSW'(set_idx) : '0;
        end
        else if (push_fin && is_unset)
        begin
            out_kind_next = 1'b1;
            kind_next  = match_found_reg ? kmtt_pkg::KIND_UNSET_DONE
                                         : kmtt_pkg::KIND_UNSET_MISS;
            owner_next = owner_reg;
            event_next = event_reg;
            slot_next  = match_found_reg ? OSW'(match_idx_reg) : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= in_opcode;
            owner_reg <= in_owner;
            event_reg <= in_event;
            dur_reg   <= in_duration;
            per_reg   <= in_periodic;
            now_reg   <= in_now;
        end
        if (cfg_we)
        begin
            cfg_mem[wr_idx] <= {owner_reg, event_reg, dur_reg, per_reg};
        end
        if (start_we)
        begin
            start_mem[wr_idx] <= now_reg;
        end
        if (rd_en)
        begin
            cfg_rd_reg   <= cfg_mem[rd_addr];
            start_rd_reg <= start_mem[rd_addr];
            eval_idx_reg <= rd_addr;
        end
        if (cmd.step && key_hit && !match_found_reg)
        begin
            match_idx_reg <= eval_idx_reg;
        end
        if (cmd.step && eval_valid_reg && !eval_active && !free_found_reg)
        begin
            free_idx_reg <= eval_idx_reg;
        end
        if (cmd.step && eval_hit)
        begin
            hold_owner_reg <= slot_owner;
            hold_event_reg <= slot_event;
            hold_idx_reg   <= eval_idx_reg;
        end
        if (push)
        begin
            out_kind_reg  <= kind_next;
            out_owner_reg <= owner_next;
            out_event_reg <= event_next;
            out_slot_reg  <= slot_next;
            out_last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= '0;
            rd_cnt_reg      <= '0;
            eval_valid_reg  <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            hold_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                rd_cnt_reg      <= '0;
                eval_valid_reg  <= 1'b0;
                match_found_reg <= 1'b0;
                free_found_reg  <= 1'b0;
            end
            if (cmd.step)
            begin
                rd_cnt_reg     <= rd_cnt_reg + CNT_W'(rd_more);
                eval_valid_reg <= rd_more;
                if (key_hit)
                begin
                    match_found_reg <= 1'b1;
                end
                if (eval_valid_reg && !eval_active)
                begin
                    free_found_reg <= 1'b1;
                end
                if (eval_hit)
                begin
                    hold_valid_reg <= 1'b1;
                    if (!slot_per)
                    begin
                        active_reg[eval_idx_reg] <= 1'b0;
                    end
                end
            end
            if (cmd.finish)
            begin
                hold_valid_reg <= 1'b0;
                if (cfg_we)
                begin
                    active_reg[set_idx] <= 1'b1;
                end
                if (is_unset && match_found_reg)
                begin
                    active_reg[match_idx_reg] <= 1'b0;
                end
            end
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_owner = out_owner_reg;
    assign out_event = out_event_reg;
    assign out_slot  = out_slot_reg;
    assign out_last  = out_last_reg;

`ifndef NO_ASSERTIONS
    a_push_into_free: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!out_valid_reg || out_ready))
        else $error("result pushed while result register is held");

    a_finish_drains_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> !hold_valid_reg)
        else $error("pending expiry left after finish");

    a_rd_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rd_cnt_reg <= CNT_W'(NUM_SLOTS))
        else $error("scan read counter out of range");

    a_eval_bound: assert property (@(posedge clk) disable iff (!rst_n)
        eval_valid_reg |-> (eval_idx_reg <= IDX_W'(NUM_SLOTS - 1)))
        else $error("evaluated slot index out of range");

    a_kind_sel: assert property (@(posedge clk) disable iff (!rst_n)
        (push && out_kind_next) |-> (is_unset && cmd.finish))
        else $error("unset result pushed outside finish");
`endif

endmodule

@@ src/keyed_multi_timer_table_unit.sv @@
// Top level of the keyed multi-timer table
`timescale 1ns / 1ps
// Every set, unset or tick scans all NUM_SLOTS slots through the slot memory, one slot
// per cycle unless the scan is stalled, with a registered read: the single result of a set
// or unset is registered at the end of the scan, after which the next item is taken.
// Expiries stream out during the tick scan; a held result stalls it only at a further expiry.
// Reset clears every active flag and all control state; slot data is not cleared and needs
// no clearing pass, since a slot is always written before it becomes active.

module keyed_multi_timer_table_unit #(
    parameter int NUM_SLOTS = 20
) (
    input logic         clk,
    input logic         rst_n,
    kmtt_in_if.sink     req,
    kmtt_out_if.source  rsp
);

    kmtt_pkg::cmd_t    cmd;
    kmtt_pkg::status_t st;

    kmtt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_op    (req.opcode),
        .in_ready (req.ready),
        .cmd      (cmd),
        .st       (st)
    );

    kmtt_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .in_opcode   (req.opcode),
        .in_owner    (req.owner_id),
        .in_event    (req.event_id),
        .in_duration (req.duration_ms),
        .in_periodic (req.is_periodic),
        .in_now      (req.now_ms),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .out_kind    (rsp.kind),
        .out_owner   (rsp.out_owner),
        .out_event   (rsp.out_event),
        .out_slot    (rsp.slot_index),
        .out_last    (rsp.last)
    );

endmodule
